### design/snor_pkg.sv
// shared types, codes and result builders for the spi nor command sequencer
`default_nettype none

package snor_pkg;

    // request function codes
    localparam logic [1:0] FUNC_START   = 2'd0;
    localparam logic [1:0] FUNC_PAYLOAD = 2'd1;
    localparam logic [1:0] FUNC_RX      = 2'd2;

    // host operation codes
    localparam logic [3:0] OP_READ    = 4'd0;
    localparam logic [3:0] OP_PROGRAM = 4'd1;
    localparam logic [3:0] OP_SECTOR  = 4'd2;
    localparam logic [3:0] OP_ERASE32 = 4'd3;
    localparam logic [3:0] OP_ERASE64 = 4'd4;
    localparam logic [3:0] OP_STATUS  = 4'd5;
    localparam logic [3:0] OP_FUNCREG = 4'd6;
    localparam logic [3:0] OP_SETPARM = 4'd7;
    localparam logic [3:0] OP_WREN    = 4'd8;

    // result kinds
    localparam logic [1:0] KIND_LINK   = 2'd0;
    localparam logic [1:0] KIND_HOST   = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    // flash opcodes
    localparam logic [7:0] CMD_READ     = 8'h03;
    localparam logic [7:0] CMD_PROGRAM  = 8'h02;
    localparam logic [7:0] CMD_WREN     = 8'h06;
    localparam logic [7:0] CMD_RDSR     = 8'h05;
    localparam logic [7:0] CMD_SECTOR   = 8'hD7;
    localparam logic [7:0] CMD_ERASE32  = 8'h52;
    localparam logic [7:0] CMD_ERASE64  = 8'hD8;
    localparam logic [7:0] CMD_RDFR     = 8'h48;
    localparam logic [7:0] CMD_SETPARM  = 8'hC0;
    localparam logic [7:0] DUMMY_BYTE   = 8'hFF;
    localparam logic [7:0] BUSY_MASK    = 8'h01;

    // sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_WREN    = 4'd1,
        PH_CMD     = 4'd2,
        PH_ADDR    = 4'd3,
        PH_RDATA   = 4'd4,
        PH_PAYLOAD = 4'd5,
        PH_PDATA   = 4'd6,
        PH_POLLCMD = 4'd7,
        PH_POLL    = 4'd8,
        PH_REGCMD  = 4'd9,
        PH_REGDATA = 4'd10,
        PH_PARCMD  = 4'd11,
        PH_PARDATA = 4'd12,
        PH_SOLO    = 4'd13
    } phase_t;

    // one result item
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] link_byte;
        logic       release_select;
        logic [7:0] host_byte;
        logic       last;
    } result_t;

    // results produced by one request
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic result_t mk_send(input logic [7:0] b, input logic rel);
        result_t r;
        r.kind           = KIND_LINK;
        r.link_byte      = b;
        r.release_select = rel;
        r.host_byte      = 8'd0;
        r.last           = 1'b0;
        return r;
    endfunction

    function automatic result_t mk_host(input logic [7:0] b);
        result_t r;
        r.kind           = KIND_HOST;
        r.link_byte      = 8'd0;
        r.release_select = 1'b0;
        r.host_byte      = b;
        r.last           = 1'b0;
        return r;
    endfunction

    function automatic result_t mk_finish();
        result_t r;
        r.kind           = KIND_FINISH;
        r.link_byte      = 8'd0;
        r.release_select = 1'b0;
        r.host_byte      = 8'd0;
        r.last           = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

### design/snor_if.sv
// request and result channel interfaces
`default_nettype none

interface snor_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [3:0]  operation;
    logic [23:0] address;
    logic [8:0]  length;
    logic [7:0]  data_byte;

    modport source (output valid, func, operation, address, length, data_byte, input ready);
    modport sink   (input valid, func, operation, address, length, data_byte, output ready);
endinterface

interface snor_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] link_byte;
    logic       release_select;
    logic [7:0] host_byte;
    logic       last;

    modport source (output valid, kind, link_byte, release_select, host_byte, last, input ready);
    modport sink   (input valid, kind, link_byte, release_select, host_byte, last, output ready);
endinterface

`default_nettype wire

### design/snor_rfifo.sv
// result queue: takes up to two results a cycle, hands out one a cycle while rsp.ready is high
`default_nettype none

module snor_rfifo #(
    parameter int DEPTH = 4
) (
    input  wire               clk,
    input  wire               rst_n,
    input  snor_pkg::push_t   push,
    output logic              space2,
    snor_rsp_if.source        rsp
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    snor_pkg::result_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] wr_ptr_inc;
    logic          pop;

    // head of queue drives the result channel
    assign pop                = rsp.valid && rsp.ready;
    assign rsp.valid          = (count_reg != '0);
    assign rsp.kind           = mem_reg[rd_ptr_reg].kind;
    assign rsp.link_byte      = mem_reg[rd_ptr_reg].link_byte;
    assign rsp.release_select = mem_reg[rd_ptr_reg].release_select;
    assign rsp.host_byte      = mem_reg[rd_ptr_reg].host_byte;
    assign rsp.last           = mem_reg[rd_ptr_reg].last;
    assign space2             = (count_reg <= CW'(DEPTH - 2));
    assign wr_ptr_inc         = wr_ptr_reg + PW'(1);

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= push.second;
        end
    end

    // queue never overfills
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("result queue overfilled");

    // pushes only land when there was room for them
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> space2)
        else $error("results pushed without room");

    // a lone pop drops the count by one
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push.count == 2'd0) |=> count_reg == $past(count_reg) - CW'(1))
        else $error("pop miscounted");

endmodule

`default_nettype wire

### design/spi_nor_command_sequencer.sv
// spi nor command sequencer top level: request decode, frame state and result queue
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   func, operation, address, length, data_byte
//   rsp      out  valid/ready   kind, link_byte, release_select, host_byte, last
//
// one request transaction is taken per cycle while req.ready is high; its zero to two results
// are written into a four entry result queue in the same cycle and leave one per cycle unless rsp stalls.
// req.ready falls only when the result queue holds more than two results.
// reset clears the phase, the saved operation, address, byte count and address index.
// a stalled rsp fills the queue and then holds req off; nothing is dropped.
`default_nettype none

module spi_nor_command_sequencer #(
    parameter int PAGE_SIZE = 256
) (
    input  wire         clk,
    input  wire         rst_n,
    snor_req_if.sink    req,
    snor_rsp_if.source  rsp
);

    localparam logic [10:0] PAGE_LIM = 11'(PAGE_SIZE);

    snor_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       op_reg, op_next;
    logic [23:0]      addr_reg, addr_next;
    logic [8:0]       left_reg, left_next;
    logic [1:0]       idx_reg, idx_next;

    snor_pkg::push_t  push;
    logic             space2;
    logic             acc;
    logic             rx_ok;
    logic [8:0]       lim;
    logic [8:0]       left_dec;
    logic [1:0]       idx_inc;
    logic             addr_rel;
    logic [7:0]       addr_byte;
    snor_pkg::result_t r0, r1;
    logic [1:0]       n;

    assign req.ready = space2;
    assign acc       = req.valid && req.ready;
    assign rx_ok     = (phase_reg != snor_pkg::PH_IDLE) && (phase_reg != snor_pkg::PH_PAYLOAD);
    assign lim       = ({2'b00, req.length} > PAGE_LIM) ? PAGE_LIM[8:0] : req.length;
    assign left_dec  = (left_reg != 9'd0) ? left_reg - 9'd1 : left_reg;
    assign idx_inc   = idx_reg + 2'd1;
    assign addr_rel  = (idx_inc == 2'd2) &&
                       ((op_reg >= snor_pkg::OP_SECTOR) || (left_reg == 9'd0));
    assign addr_byte = (idx_reg == 2'd0) ? addr_reg[15:8] : addr_reg[7:0];

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        op_next    = op_reg;
        addr_next  = addr_reg;
        left_next  = left_reg;
        idx_next   = idx_reg;
        if (acc)
        begin
            unique case (req.func)
                snor_pkg::FUNC_START:
                begin
                    if (phase_reg == snor_pkg::PH_IDLE)
                    begin
                        op_next   = req.operation;
                        addr_next = req.address;
                        left_next = 9'd0;
                        idx_next  = 2'd0;
                        unique case (req.operation)
                            snor_pkg::OP_READ:
                            begin
                                left_next  = lim;
                                phase_next = snor_pkg::PH_CMD;
                            end
                            snor_pkg::OP_PROGRAM:
                            begin
                                left_next  = lim;
                                phase_next = snor_pkg::PH_WREN;
                            end
                            snor_pkg::OP_SECTOR,
                            snor_pkg::OP_ERASE32,
                            snor_pkg::OP_ERASE64: phase_next = snor_pkg::PH_CMD;
                            snor_pkg::OP_STATUS,
                            snor_pkg::OP_FUNCREG: phase_next = snor_pkg::PH_REGCMD;
                            snor_pkg::OP_SETPARM:
                            begin
                                addr_next  = {16'd0, req.data_byte};
                                phase_next = snor_pkg::PH_PARCMD;
                            end
                            snor_pkg::OP_WREN: phase_next = snor_pkg::PH_SOLO;
                            default: phase_next = snor_pkg::PH_IDLE;
                        endcase
                    end
                end
                snor_pkg::FUNC_PAYLOAD:
                begin
                    if (phase_reg == snor_pkg::PH_PAYLOAD)
                    begin
                        phase_next = snor_pkg::PH_PDATA;
                    end
                end
                snor_pkg::FUNC_RX:
                begin
                    unique case (phase_reg)
                        snor_pkg::PH_WREN: phase_next = snor_pkg::PH_CMD;
                        snor_pkg::PH_CMD:
                        begin
                            phase_next = snor_pkg::PH_ADDR;
                            idx_next   = 2'd0;
                        end
                        snor_pkg::PH_ADDR:
                        begin
                            priority if (idx_reg < 2'd2)
                            begin
                                idx_next = idx_inc;
                            end
                            else if (op_reg == snor_pkg::OP_READ)
                            begin
                                phase_next = (left_reg == 9'd0) ? snor_pkg::PH_IDLE
                                                                : snor_pkg::PH_RDATA;
                            end
                            else if (op_reg == snor_pkg::OP_PROGRAM && left_reg != 9'd0)
                            begin
                                phase_next = snor_pkg::PH_PAYLOAD;
                            end
                            else
                            begin
                                phase_next = snor_pkg::PH_POLLCMD;
                            end
                        end
                        snor_pkg::PH_RDATA:
                        begin
                            left_next = left_dec;
                            if (left_dec == 9'd0)
                            begin
                                phase_next = snor_pkg::PH_IDLE;
                            end
                        end
                        snor_pkg::PH_PDATA:
                        begin
                            left_next  = left_dec;
                            phase_next = (left_dec != 9'd0) ? snor_pkg::PH_PAYLOAD
                                                            : snor_pkg::PH_POLLCMD;
                        end
                        snor_pkg::PH_POLLCMD: phase_next = snor_pkg::PH_POLL;
                        snor_pkg::PH_POLL:
                        begin
                            if ((req.data_byte & snor_pkg::BUSY_MASK) == 8'd0)
                            begin
                                phase_next = snor_pkg::PH_IDLE;
                            end
                        end
                        snor_pkg::PH_REGCMD:  phase_next = snor_pkg::PH_REGDATA;
                        snor_pkg::PH_PARCMD:  phase_next = snor_pkg::PH_PARDATA;
                        snor_pkg::PH_REGDATA,
                        snor_pkg::PH_PARDATA,
                        snor_pkg::PH_SOLO:    phase_next = snor_pkg::PH_IDLE;
                        default:              phase_next = phase_reg;
                    endcase
                end
                default: phase_next = phase_reg;
            endcase
        end
    end

    // results of the accepted request
    always_comb
    begin
        r0 = snor_pkg::mk_finish();
        r1 = snor_pkg::mk_finish();
        n  = 2'd0;
        if (acc)
        begin
            unique case (req.func)
                snor_pkg::FUNC_START:
                begin
                    if (phase_reg == snor_pkg::PH_IDLE)
                    begin
                        n = 2'd1;
                        unique case (req.operation)
                            snor_pkg::OP_READ:    r0 = snor_pkg::mk_send(snor_pkg::CMD_READ, 1'b0);
                            snor_pkg::OP_PROGRAM: r0 = snor_pkg::mk_send(snor_pkg::CMD_WREN, 1'b1);
                            snor_pkg::OP_SECTOR:  r0 = snor_pkg::mk_send(snor_pkg::CMD_SECTOR, 1'b0);
                            snor_pkg::OP_ERASE32: r0 = snor_pkg::mk_send(snor_pkg::CMD_ERASE32, 1'b0);
                            snor_pkg::OP_ERASE64: r0 = snor_pkg::mk_send(snor_pkg::CMD_ERASE64, 1'b0);
                            snor_pkg::OP_STATUS:  r0 = snor_pkg::mk_send(snor_pkg::CMD_RDSR, 1'b0);
                            snor_pkg::OP_FUNCREG: r0 = snor_pkg::mk_send(snor_pkg::CMD_RDFR, 1'b0);
                            snor_pkg::OP_SETPARM: r0 = snor_pkg::mk_send(snor_pkg::CMD_SETPARM, 1'b0);
                            snor_pkg::OP_WREN:    r0 = snor_pkg::mk_send(snor_pkg::CMD_WREN, 1'b1);
                            default:              r0 = snor_pkg::mk_finish();
                        endcase
                    end
                end
                snor_pkg::FUNC_PAYLOAD:
                begin
                    if (phase_reg == snor_pkg::PH_PAYLOAD)
                    begin
                        n  = 2'd1;
                        r0 = snor_pkg::mk_send(req.data_byte, left_reg == 9'd1);
                    end
                end
                snor_pkg::FUNC_RX:
                begin
                    if (rx_ok)
                    begin
                        n = 2'd1;
                        unique case (phase_reg)
                            snor_pkg::PH_WREN:
                                r0 = snor_pkg::mk_send(snor_pkg::CMD_PROGRAM, 1'b0);
                            snor_pkg::PH_CMD:
                                r0 = snor_pkg::mk_send(addr_reg[23:16], 1'b0);
                            snor_pkg::PH_ADDR:
                            begin
                                priority if (idx_reg < 2'd2)
                                begin
                                    r0 = snor_pkg::mk_send(addr_byte, addr_rel);
                                end
                                else if (op_reg == snor_pkg::OP_READ)
                                begin
                                    r0 = (left_reg == 9'd0) ? snor_pkg::mk_finish()
                                         : snor_pkg::mk_send(snor_pkg::DUMMY_BYTE,
                                                             left_reg == 9'd1);
                                end
                                else if (op_reg == snor_pkg::OP_PROGRAM && left_reg != 9'd0)
                                begin
                                    n = 2'd0;
                                end
                                else
                                begin
                                    r0 = snor_pkg::mk_send(snor_pkg::CMD_RDSR, 1'b0);
                                end
                            end
                            snor_pkg::PH_RDATA:
                            begin
                                n  = 2'd2;
                                r0 = snor_pkg::mk_host(req.data_byte);
                                r1 = (left_dec != 9'd0)
                                     ? snor_pkg::mk_send(snor_pkg::DUMMY_BYTE, left_dec == 9'd1)
                                     : snor_pkg::mk_finish();
                            end
                            snor_pkg::PH_PDATA:
                            begin
                                if (left_dec != 9'd0)
                                begin
                                    n = 2'd0;
                                end
                                else
                                begin
                                    r0 = snor_pkg::mk_send(snor_pkg::CMD_RDSR, 1'b0);
                                end
                            end
                            snor_pkg::PH_POLLCMD:
                                r0 = snor_pkg::mk_send(snor_pkg::DUMMY_BYTE, 1'b0);
                            snor_pkg::PH_POLL:
                            begin
                                r0 = ((req.data_byte & snor_pkg::BUSY_MASK) != 8'd0)
                                     ? snor_pkg::mk_send(snor_pkg::DUMMY_BYTE, 1'b0)
                                     : snor_pkg::mk_finish();
                            end
                            snor_pkg::PH_REGCMD:
                                r0 = snor_pkg::mk_send(snor_pkg::DUMMY_BYTE, 1'b1);
                            snor_pkg::PH_REGDATA:
                            begin
                                n  = 2'd2;
                                r0 = snor_pkg::mk_host(req.data_byte);
                                r1 = snor_pkg::mk_finish();
                            end
                            snor_pkg::PH_PARCMD:
                                r0 = snor_pkg::mk_send(addr_reg[7:0], 1'b1);
                            snor_pkg::PH_PARDATA,
                            snor_pkg::PH_SOLO:
                                r0 = snor_pkg::mk_finish();
                            default:
                                n = 2'd0;
                        endcase
                    end
                end
                default: n = 2'd0;
            endcase
        end
        // mark the final result of this transaction
        if (n == 2'd1)
        begin
            r0.last = 1'b1;
        end
        if (n == 2'd2)
        begin
            r1.last = 1'b1;
        end
    end

    assign push.count  = n;
    assign push.first  = r0;
    assign push.second = r1;

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= snor_pkg::PH_IDLE;
            op_reg    <= 4'd0;
            addr_reg  <= 24'd0;
            left_reg  <= 9'd0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            op_reg    <= op_next;
            addr_reg  <= addr_next;
            left_reg  <= left_next;
            idx_reg   <= idx_next;
        end
    end

    // result queue
    snor_rfifo #(
        .DEPTH (4)
    ) u_rfifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .space2 (space2),
        .rsp    (rsp)
    );

    // a read data phase always has bytes still to come
    a_rdata_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == snor_pkg::PH_RDATA |-> left_reg != 9'd0)
        else $error("read data phase with no bytes left");

    // payload wait only happens inside a program with bytes left
    a_payload_prog: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == snor_pkg::PH_PAYLOAD |-> (op_reg == snor_pkg::OP_PROGRAM && left_reg != 9'd0))
        else $error("payload wait outside a program");

    // returning to idle always comes with a finish result
    a_idle_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != snor_pkg::PH_IDLE && phase_next == snor_pkg::PH_IDLE) |->
        (n != 2'd0 && ((n == 2'd1 && r0.kind == snor_pkg::KIND_FINISH) ||
                       (n == 2'd2 && r1.kind == snor_pkg::KIND_FINISH))))
        else $error("went idle without a finish result");

    // address index stays within the three address bytes
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 2'd3)
        else $error("address index out of range");

endmodule

`default_nettype wire

### bench/testbench.sv
// self-checking testbench for the spi nor command sequencer: scoreboard class and stimulus
import snor_pkg::*;

// expected-result tracker: mirrors the sequencer state and queues the frame bytes it must emit
class frame_scoreboard;
    result_t     expected_q[$];
    result_t     batch[$];
    phase_t      ph;
    logic [3:0]  cur_op;
    logic [23:0] addr_hold;
    logic [8:0]  remaining;
    logic [1:0]  addr_idx;
    int          page_limit;
    int          errors;
    int          results_checked;
    int          busy_polls;

    function new(int page);
        page_limit      = page;
        ph              = PH_IDLE;
        cur_op          = 4'd0;
        addr_hold       = 24'd0;
        remaining       = 9'd0;
        addr_idx        = 2'd0;
        errors          = 0;
        results_checked = 0;
        busy_polls      = 0;
    endfunction

    function void emit(logic [1:0] kind, logic [7:0] link, logic rel, logic [7:0] host);
        result_t r;
        r.kind           = kind;
        r.link_byte      = link;
        r.release_select = rel;
        r.host_byte      = host;
        r.last           = 1'b0;
        batch.push_back(r);
    endfunction

    function void link_out(logic [7:0] b, logic rel);
        emit(KIND_LINK, b, rel, 8'd0);
    endfunction

    function void done();
        ph = PH_IDLE;
        emit(KIND_FINISH, 8'd0, 1'b0, 8'd0);
    endfunction

    function void poll_start();
        ph = PH_POLLCMD;
        link_out(CMD_RDSR, 1'b0);
    endfunction

    // new host request while idle
    function void start_op(logic [3:0] op, logic [23:0] addr, logic [8:0] len, logic [7:0] db);
        logic [8:0] lim;
        lim       = (len > page_limit) ? page_limit[8:0] : len;
        cur_op    = op;
        addr_hold = addr;
        remaining = 9'd0;
        addr_idx  = 2'd0;
        case (op)
            OP_READ:    begin remaining = lim; ph = PH_CMD;  link_out(CMD_READ, 1'b0); end
            OP_PROGRAM: begin remaining = lim; ph = PH_WREN; link_out(CMD_WREN, 1'b1); end
            OP_SECTOR:  begin ph = PH_CMD; link_out(CMD_SECTOR, 1'b0); end
            OP_ERASE32: begin ph = PH_CMD; link_out(CMD_ERASE32, 1'b0); end
            OP_ERASE64: begin ph = PH_CMD; link_out(CMD_ERASE64, 1'b0); end
            OP_STATUS:  begin ph = PH_REGCMD; link_out(CMD_RDSR, 1'b0); end
            OP_FUNCREG: begin ph = PH_REGCMD; link_out(CMD_RDFR, 1'b0); end
            OP_SETPARM:
            begin
                // parameter byte rides in the low address byte until sent
                addr_hold = {16'd0, db};
                ph        = PH_PARCMD;
                link_out(CMD_SETPARM, 1'b0);
            end
            OP_WREN:    begin ph = PH_SOLO; link_out(CMD_WREN, 1'b1); end
            default:    done();
        endcase
    endfunction

    // byte returned from the link
    function void link_rx(logic [7:0] rx);
        logic rel;
        case (ph)
            PH_WREN:
            begin
                ph = PH_CMD;
                link_out(CMD_PROGRAM, 1'b0);
            end
            PH_CMD:
            begin
                ph       = PH_ADDR;
                addr_idx = 2'd0;
                link_out(addr_hold[23:16], 1'b0);
            end
            PH_ADDR:
            begin
                if (addr_idx < 2'd2)
                begin
                    addr_idx = addr_idx + 2'd1;
                    rel = (addr_idx == 2'd2) && (cur_op >= OP_SECTOR || remaining == 9'd0);
                    link_out((addr_idx == 2'd1) ? addr_hold[15:8] : addr_hold[7:0], rel);
                end
                else if (cur_op == OP_READ)
                begin
                    if (remaining == 9'd0)
                        done();
                    else
                    begin
                        ph = PH_RDATA;
                        link_out(DUMMY_BYTE, remaining == 9'd1);
                    end
                end
                else if (cur_op == OP_PROGRAM && remaining != 9'd0)
                    ph = PH_PAYLOAD;
                else
                    poll_start();
            end
            PH_RDATA:
            begin
                emit(KIND_HOST, 8'd0, 1'b0, rx);
                if (remaining != 9'd0)
                    remaining = remaining - 9'd1;
                if (remaining != 9'd0)
                    link_out(DUMMY_BYTE, remaining == 9'd1);
                else
                    done();
            end
            PH_PDATA:
            begin
                if (remaining != 9'd0)
                    remaining = remaining - 9'd1;
                if (remaining != 9'd0)
                    ph = PH_PAYLOAD;
                else
                    poll_start();
            end
            PH_POLLCMD:
            begin
                ph = PH_POLL;
                link_out(DUMMY_BYTE, 1'b0);
            end
            PH_POLL:
            begin
                // polled status stays inside the block
                if ((rx & BUSY_MASK) != 8'd0)
                begin
                    busy_polls++;
                    link_out(DUMMY_BYTE, 1'b0);
                end
                else
                    done();
            end
            PH_REGCMD:
            begin
                ph = PH_REGDATA;
                link_out(DUMMY_BYTE, 1'b1);
            end
            PH_REGDATA:
            begin
                emit(KIND_HOST, 8'd0, 1'b0, rx);
                done();
            end
            PH_PARCMD:
            begin
                ph = PH_PARDATA;
                link_out(addr_hold[7:0], 1'b1);
            end
            PH_PARDATA, PH_SOLO:
                done();
            default: ;
        endcase
    endfunction

    // accepted request transaction: update state and queue its results
    function void note_request(logic [1:0] func, logic [3:0] op, logic [23:0] addr,
                               logic [8:0] len, logic [7:0] db);
        batch.delete();
        case (func)
            FUNC_START:
                if (ph == PH_IDLE)
                    start_op(op, addr, len, db);
            FUNC_PAYLOAD:
                if (ph == PH_PAYLOAD)
                begin
                    ph = PH_PDATA;
                    link_out(db, remaining == 9'd1);
                end
            FUNC_RX:
                if (ph != PH_IDLE && ph != PH_PAYLOAD)
                    link_rx(db);
            default: ;
        endcase
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            expected_q.push_back(batch[i]);
    endfunction

    function void field_check(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // accepted result transaction against the oldest expectation
    function void check_result(result_t got);
        result_t want;
        results_checked++;
        if (expected_q.size() == 0)
        begin
            errors++;
            $display({"%0t: unexpected result, expected none actual kind %0h link %0h",
                      " rel %0b host %0h last %0b"},
                     $time, got.kind, got.link_byte, got.release_select, got.host_byte,
                     got.last);
            return;
        end
        want = expected_q.pop_front();
        field_check("kind", want.kind, got.kind);
        field_check("link_byte", want.link_byte, got.link_byte);
        field_check("release_select", want.release_select, got.release_select);
        field_check("host_byte", want.host_byte, got.host_byte);
        field_check("last", want.last, got.last);
    endfunction
endclass

module testbench;
    localparam int         PAGE_BYTES  = 256;
    localparam logic [1:0] FUNC_SPARE  = 2'd3;
    localparam int         ITEM_TARGET = 220;

    logic clk;
    logic rst_n;
    bit   calm;
    int   items_sent;
    int   noise_sent;
    int   ops_run;
    int   waited;

    frame_scoreboard sb = new(PAGE_BYTES);

    snor_req_if req_ch ();
    snor_rsp_if rsp_ch ();

    spi_nor_command_sequencer #(.PAGE_SIZE(PAGE_BYTES)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run limit
    initial
    begin
        #3000000;
        $display("testbench NOT OK");
        $finish;
    end

    // one request transaction, driven at the falling edge, accepted at a rising edge
    task automatic drive_item(input logic [1:0] f, input logic [3:0] op, input logic [23:0] addr,
                              input logic [8:0] len, input logic [7:0] db);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid     = 1'b1;
        req_ch.func      = f;
        req_ch.operation = op;
        req_ch.address   = addr;
        req_ch.length    = len;
        req_ch.data_byte = db;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(f, op, addr, len, db);
        items_sent++;
        @(negedge clk);
        // nothing offered until the next transaction is driven
        req_ch.valid = 1'b0;
    endtask

    // hold the request side until every queued result has come out
    task automatic drain();
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // out-of-turn request that the current phase must ignore
    task automatic inject_noise();
        logic [1:0] f;
        int pick;
        pick = $urandom_range(0, 2);
        if (sb.ph == PH_IDLE)
            f = (pick == 0) ? FUNC_PAYLOAD : (pick == 1) ? FUNC_RX : FUNC_SPARE;
        else if (sb.ph == PH_PAYLOAD)
            f = (pick == 0) ? FUNC_START : (pick == 1) ? FUNC_RX : FUNC_SPARE;
        else
            f = (pick == 0) ? FUNC_START : (pick == 1) ? FUNC_PAYLOAD : FUNC_SPARE;
        drive_item(f, 4'($urandom_range(0, 15)), 24'($urandom_range(0, 24'hFFFFFF)),
                   9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
        noise_sent++;
    endtask

    // next in-turn request: payload byte or link reply
    task automatic advance_operation();
        logic [7:0] rx;
        if (sb.ph == PH_PAYLOAD)
            drive_item(FUNC_PAYLOAD, 4'($urandom_range(0, 15)),
                       24'($urandom_range(0, 24'hFFFFFF)), 9'($urandom_range(0, 511)),
                       8'($urandom_range(0, 255)));
        else
        begin
            rx = 8'($urandom_range(0, 255));
            // keep status polls short but let busy show up
            if (sb.ph == PH_POLL)
                rx[0] = ($urandom_range(0, 2) == 0);
            drive_item(FUNC_RX, 4'($urandom_range(0, 15)), 24'($urandom_range(0, 24'hFFFFFF)),
                       9'($urandom_range(0, 511)), rx);
        end
    endtask

    // whole host operation with link replies, optionally sprinkled with ignored requests
    task automatic run_operation(input logic [3:0] op, input logic [23:0] addr,
                                 input logic [8:0] len, input logic [7:0] db, input int noise_pct);
        drive_item(FUNC_START, op, addr, len, db);
        ops_run++;
        while (sb.ph != PH_IDLE)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                inject_noise();
            advance_operation();
        end
    endtask

    // result side: random stall per transaction
    initial
    begin
        result_t got;
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready = 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            got.kind           = rsp_ch.kind;
            got.link_byte      = rsp_ch.link_byte;
            got.release_select = rsp_ch.release_select;
            got.host_byte      = rsp_ch.host_byte;
            got.last           = rsp_ch.last;
            sb.check_result(got);
            @(negedge clk);
        end
    end

    // main stimulus
    initial
    begin
        logic [3:0] op;
        logic [8:0] len;
        int pick;
        rst_n            = 1'b0;
        calm             = 1'b0;
        items_sent       = 0;
        noise_sent       = 0;
        ops_run          = 0;
        req_ch.valid     = 1'b0;
        req_ch.func      = FUNC_START;
        req_ch.operation = OP_READ;
        req_ch.address   = 24'd0;
        req_ch.length    = 9'd0;
        req_ch.data_byte = 8'd0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: ignored requests at idle, unknown operation, each short command
        inject_noise();
        inject_noise();
        inject_noise();
        run_operation(4'hF, 24'hFFFFFF, 9'd511, 8'hFF, 0);
        drain();
        run_operation(OP_WREN, 24'd0, 9'd0, 8'h00, 0);
        drain();
        run_operation(OP_STATUS, 24'd0, 9'd0, 8'h00, 0);
        drain();
        run_operation(OP_FUNCREG, 24'd0, 9'd0, 8'h00, 0);
        drain();
        run_operation(OP_SETPARM, 24'hFFFF00, 9'd0, 8'hFF, 0);
        drain();
        // zero-length read and program, then a one-byte program with stray requests
        run_operation(OP_READ, 24'hFFFFFF, 9'd0, 8'h00, 0);
        drain();
        run_operation(OP_PROGRAM, 24'h000000, 9'd0, 8'h00, 0);
        drain();
        run_operation(OP_PROGRAM, 24'h5A3C96, 9'd1, 8'h00, 50);
        drain();

        // random operations with random content
        while (items_sent < ITEM_TARGET)
        begin
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 4) == 0)
                drain();
            if ($urandom_range(0, 5) == 0)
                inject_noise();
            pick = $urandom_range(0, 19);
            op   = (pick < 18) ? 4'(pick % 9) : 4'($urandom_range(9, 15));
            pick = $urandom_range(0, 19);
            if (op == OP_READ || op == OP_PROGRAM)
                len = (pick < 15) ? 9'($urandom_range(0, 4)) :
                      (pick < 19) ? 9'($urandom_range(5, 16)) : 9'($urandom_range(17, 40));
            else
                len = 9'($urandom_range(0, 511));
            run_operation(op, 24'($urandom_range(0, 24'hFFFFFF)), len,
                          8'($urandom_range(0, 255)), 12);
        end

        // wind down
        calm         = 1'b0;
        req_ch.valid = 1'b0;
        waited       = 0;
        while (sb.expected_q.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (sb.expected_q.size() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d expected results never arrived", $time, sb.expected_q.size());
        end

        $display("run covered %0d operations in %0d request transactions (%0d out of turn)",
                 ops_run, items_sent, noise_sent);
        $display("%0d results compared, %0d busy status polls, %0d mismatches",
                 sb.results_checked, sb.busy_polls, sb.errors);
        if (sb.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
